// File: hdl/sit_pkg.sv
package sit_pkg;

	localparam int ID_W       = 32;
	localparam int STATUS_W   = 2;
	localparam int POSITION_W = 6;
	localparam int COUNT_W    = 7;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_PRESENT   = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_LOOKUP = 1'b1
	} command_t;

	// Control broadcast to every cell.
	typedef struct packed {
		logic compare;
		logic shift;
	} cell_ctrl_t;

	// Data handed from one cell to its upper neighbour.
	typedef struct packed {
		logic [ID_W-1:0] entry;
		logic            lt;
	} cell_link_t;

	// Per-cell result of the comparison stage.
	typedef struct packed {
		logic boundary;
		logic hit;
	} cell_stat_t;

endpackage

// File: hdl/sit_cell.sv
module sit_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sit_pkg::cell_ctrl_t       ctrl,
	input  logic [sit_pkg::ID_W-1:0]  key,
	input  logic                      valid,
	input  sit_pkg::cell_link_t       left,
	output sit_pkg::cell_link_t       right,
	output sit_pkg::cell_stat_t       stat
);
	import sit_pkg::*;

	logic [ID_W-1:0] entry_q;
	logic            lt_s1;
	logic            eq_s1;
	logic            boundary;

	// The cell holding the first entry not less than the key sits just above
	// the last cell whose entry is less than it.
	assign boundary      = left.lt & ~lt_s1;
	assign stat.boundary = boundary;
	assign stat.hit      = boundary & eq_s1;
	assign right.entry   = entry_q;
	assign right.lt      = lt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_s1 <= 1'b0;
			eq_s1 <= 1'b0;
		end else if (ctrl.compare) begin
			lt_s1 <= valid & (entry_q < key);
			eq_s1 <= valid & (entry_q == key);
		end
	end

	// Cells below the insertion point keep their entry; the boundary cell
	// takes the key and every cell above it takes its lower neighbour's entry.
	always_ff @(posedge clk) begin
		if (ctrl.shift && !lt_s1) begin
			entry_q <= boundary ? key : left.entry;
		end
	end

endmodule

// File: hdl/sorted_id_table.sv
// Sorted id table: holds up to CAPACITY distinct 32-bit ids in ascending
// order in a row of cells, each cell holding one entry. An insert command
// places the id at its lower-bound position, moving every larger entry up
// one cell together; it reports "already present" if the id is
// held and "table full" if there is no room. A lookup returns the id's rank
// or "not found". Every result carries the number of ids held after the
// command. A command is first accepted; then every cell compares its entry
// with the id at once and registers the outcome; then, once the output
// register is free, the boundary cell is located, the row shifts and the
// result register is loaded. One command is in the cells at a time, so the
// block takes no new command until it is through with the last one; a
// finished result waits in its own register, so the next command may be
// transferred in while the previous result is still stalled. There is no
// clearing pass after reset: only entries below the count are ever read.
module sorted_id_table #(
	parameter int CAPACITY = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic [sit_pkg::ID_W-1:0]      id,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sit_pkg::STATUS_W-1:0]  status,
	output logic [sit_pkg::POSITION_W-1:0] position,
	output logic [sit_pkg::COUNT_W-1:0]   entry_count
);
	import sit_pkg::*;

	localparam int PosW = $clog2(CAPACITY);
	localparam int CntW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_COMPARE,
		S_APPLY
	} state_t;

	state_t                state_q;
	logic [ID_W-1:0]       key_s1;
	command_t              cmd_s1;
	logic [CntW-1:0]       count_q;
	status_t               status_q;
	logic [POSITION_W-1:0] position_q;
	logic [COUNT_W-1:0]    entry_count_q;
	logic                  out_valid_q;

	cell_ctrl_t            ctrl;
	cell_link_t            link [CAPACITY+1];
	cell_stat_t            stat [CAPACITY];
	logic [CAPACITY-1:0]   valid_vec;

	logic                  in_xfer;
	logic                  out_free;
	logic                  apply_go;
	logic                  hit;
	logic [PosW-1:0]       pos;
	logic                  full;
	logic                  do_insert;
	logic [CntW-1:0]       count_next;
	status_t               status_d;
	logic [31:0]           pos_ext;
	logic [31:0]           cnt_ext;

	// A command is taken only while the cells are free; the result register
	// stands apart, so a waiting result does not hold the input back.
	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid & ~in_stall;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign apply_go  = (state_q == S_APPLY) & out_free;

	// The bottom of the row sees an imaginary entry below every key.
	assign link[0].entry = key_s1;
	assign link[0].lt    = 1'b1;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign valid_vec[i] = (CntW'(i) < count_q);

		sit_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.key    (key_s1),
			.valid  (valid_vec[i]),
			.left   (link[i]),
			.right  (link[i+1]),
			.stat   (stat[i])
		);
	end

	// Exactly one cell marks the boundary unless the table is full and every
	// entry is below the key; the encoder then gives zero, which the full
	// case never reports.
	always_comb begin
		hit = 1'b0;
		pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit = hit | stat[i].hit;
			pos = pos | (stat[i].boundary ? PosW'(i) : '0);
		end
	end

	assign full      = (count_q == CntW'(CAPACITY));
	assign do_insert = (cmd_s1 == CMD_INSERT) & ~hit & ~full;
	assign count_next = do_insert ? count_q + 1'b1 : count_q;

	always_comb begin
		if (cmd_s1 == CMD_LOOKUP) begin
			status_d = hit ? ST_OK : ST_NOT_FOUND;
		end else if (hit) begin
			status_d = ST_PRESENT;
		end else if (full) begin
			status_d = ST_FULL;
		end else begin
			status_d = ST_OK;
		end
	end

	// Position and count are reported at their field widths.
	assign pos_ext = (status_d == ST_OK) ? 32'(pos) : 32'd0;
	assign cnt_ext = 32'(count_next);

	assign ctrl.compare = (state_q == S_COMPARE);
	assign ctrl.shift   = apply_go & do_insert;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces the old one in the cycle it is taken.
			if (apply_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_COMPARE;
					end
				end
				S_COMPARE: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (out_free) begin
						count_q <= count_next;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			key_s1 <= id;
			cmd_s1 <= command_t'(command);
		end
		if (apply_go) begin
			status_q      <= status_d;
			position_q    <= pos_ext[POSITION_W-1:0];
			entry_count_q <= cnt_ext[COUNT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign position    = position_q;
	assign entry_count = entry_count_q;

endmodule
